// ===== design/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, codes, font and constant-divider tables for the seven-segment
// scan driver
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

	localparam int SEG_W       = 8;
	localparam int EN_W        = 8;
	localparam int HEX_W       = 16;
	localparam int NUM_W       = 16;
	localparam int FRAMES_W    = 16;
	localparam int DWELL_W     = 16;
	localparam int DOT_W       = 3;
	localparam int MODE_W      = 2;
	localparam int NIB_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// op codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// display modes, the remaining code falls back to hex
	localparam logic [MODE_W-1:0] MODE_HEX    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEC    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_YELLOW = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YDWELL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MINUS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DOTMASK = 2'd3;

	// register reset values
	localparam logic [DWELL_W-1:0] DWELL_RST   = 16'd5000;
	localparam logic [DWELL_W-1:0] YDWELL_RST  = 16'd2500;
	localparam logic [SEG_W-1:0]   MINUS_RST   = 8'h40;
	localparam logic [SEG_W-1:0]   DOTMASK_RST = 8'h80;

	// decimal places a 16-bit magnitude can have
	localparam int QUOT_N = 5;
	// x / 10^k as (x * DEC_MUL[k]) >> DEC_SHIFT[k], exact for any 16-bit x
	localparam int DEC_MUL   [QUOT_N] = '{1, 104858, 83887, 67109, 107375};
	localparam int DEC_SHIFT [QUOT_N] = '{0, 20, 23, 26, 30};
	localparam int PROD_W = 33;

	// control travelling with each beat from the front end to the scan stage
	typedef struct packed {
		logic                is_load;
		logic                rejected;
		logic                is_dec;
		logic                yellow;
		logic                bank;
		logic [FRAMES_W-1:0] frames_run;
	} ld_ctl_t;

	function automatic int pow10(input int k);
		int r;
		r = 1;
		for (int i = 0; i < k; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	function automatic logic [SEG_W-1:0] seg_font(input logic [NIB_W-1:0] nib);
		logic [SEG_W-1:0] p;
		unique case (nib)
			4'h0: p = 8'h3F;
			4'h1: p = 8'h06;
			4'h2: p = 8'h5B;
			4'h3: p = 8'h4F;
			4'h4: p = 8'h66;
			4'h5: p = 8'h6D;
			4'h6: p = 8'h7D;
			4'h7: p = 8'h07;
			4'h8: p = 8'h7F;
			4'h9: p = 8'h6F;
			4'hA: p = 8'h77;
			4'hB: p = 8'h7C;
			4'hC: p = 8'h39;
			4'hD: p = 8'h5E;
			4'hE: p = 8'h79;
			4'hF: p = 8'h71;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== design/ssd_cfg.sv =====
// ----------------------------------------------------------------------------
// ssd_cfg
// configuration register file: dwell times, minus pattern and dot mask
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [ssd_pkg::DWELL_W-1:0]           dwell_q,
	output logic [ssd_pkg::DWELL_W-1:0]           ydwell_q,
	output logic [ssd_pkg::SEG_W-1:0]             minus_q,
	output logic [ssd_pkg::SEG_W-1:0]             dotmask_q
);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q   <= ssd_pkg::DWELL_RST;
			ydwell_q  <= ssd_pkg::YDWELL_RST;
			minus_q   <= ssd_pkg::MINUS_RST;
			dotmask_q <= ssd_pkg::DOTMASK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ssd_pkg::CFG_DWELL:   dwell_q   <= cfg_data;
				ssd_pkg::CFG_YDWELL:  ydwell_q  <= cfg_data;
				ssd_pkg::CFG_MINUS:   minus_q   <= cfg_data[ssd_pkg::SEG_W-1:0];
				ssd_pkg::CFG_DOTMASK: dotmask_q <= cfg_data[ssd_pkg::SEG_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/ssd_front.sv =====
// ----------------------------------------------------------------------------
// ssd_front
// input register, load decode, range check and decimal quotients by
// reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_front #(
	parameter int NUM_DIGITS = 4
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          in_valid,
	output logic                                               in_ready,
	input  wire logic                                          op,
	input  wire logic [ssd_pkg::MODE_W-1:0]                    mode,
	input  wire logic [ssd_pkg::HEX_W-1:0]                     hex_value,
	input  wire logic signed [ssd_pkg::NUM_W-1:0]              signed_number,
	input  wire logic [ssd_pkg::DOT_W-1:0]                     dot_pos,
	input  wire logic                                          color,
	input  wire logic [ssd_pkg::FRAMES_W-1:0]                  frames,
	output logic                                               valid_s2,
	input  wire logic                                          down_ready,
	output ssd_pkg::ld_ctl_t                                   ctl_s2,
	output logic [ssd_pkg::QUOT_N-1:0][ssd_pkg::NUM_W-1:0]     quot_s2,
	output logic                                               neg_s2,
	output logic [ssd_pkg::HEX_W-1:0]                          hex_s2,
	output logic [ssd_pkg::DOT_W-1:0]                          dot_pos_s2
);

	localparam int DEC_LO = -(ssd_pkg::pow10(NUM_DIGITS - 1) - 1);
	localparam int DEC_HI = ssd_pkg::pow10(NUM_DIGITS) - 1;

	logic                               valid_s1;
	logic                               op_s1;
	logic [ssd_pkg::MODE_W-1:0]         mode_s1;
	logic [ssd_pkg::HEX_W-1:0]          hex_s1;
	logic signed [ssd_pkg::NUM_W-1:0]   num_s1;
	logic [ssd_pkg::DOT_W-1:0]          dot_s1;
	logic                               color_s1;
	logic [ssd_pkg::FRAMES_W-1:0]       frames_s1;

	logic                                              s2_ready;
	ssd_pkg::ld_ctl_t                                  ctl_d;
	logic [ssd_pkg::QUOT_N-1:0][ssd_pkg::NUM_W-1:0]    quot_d;
	logic [ssd_pkg::NUM_W-1:0]                         mag;
	logic                                              in_range;

	assign s2_ready = !valid_s2 || down_ready;
	assign in_ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= op;
			mode_s1   <= mode;
			hex_s1    <= hex_value;
			num_s1    <= signed_number;
			dot_s1    <= dot_pos;
			color_s1  <= color;
			frames_s1 <= frames;
		end
	end

	// sign, magnitude and decode
	always_comb begin
		in_range = (int'(num_s1) >= DEC_LO) && (int'(num_s1) <= DEC_HI);
		mag      = num_s1[ssd_pkg::NUM_W-1] ? ssd_pkg::NUM_W'(-num_s1)
		                                    : ssd_pkg::NUM_W'(num_s1);
		ctl_d.is_load  = (op_s1 == ssd_pkg::OP_LOAD);
		ctl_d.is_dec   = (mode_s1 == ssd_pkg::MODE_DEC);
		ctl_d.yellow   = (mode_s1 == ssd_pkg::MODE_YELLOW);
		ctl_d.rejected = ctl_d.is_load && ctl_d.is_dec && !in_range;
		ctl_d.bank     = ctl_d.yellow ? 1'b1 : color_s1;
		ctl_d.frames_run = ctl_d.yellow ? {1'b0, frames_s1[ssd_pkg::FRAMES_W-1:1]}
		                                : frames_s1;
	end

	// mag / 10^k for each decimal place
	always_comb begin
		logic [ssd_pkg::PROD_W-1:0] prod;
		prod = '0;
		for (int k = 0; k < ssd_pkg::QUOT_N; k++) begin
			prod      = ssd_pkg::PROD_W'(mag) * ssd_pkg::PROD_W'(ssd_pkg::DEC_MUL[k]);
			quot_d[k] = ssd_pkg::NUM_W'(prod >> ssd_pkg::DEC_SHIFT[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			ctl_s2     <= ctl_d;
			quot_s2    <= quot_d;
			neg_s2     <= num_s1[ssd_pkg::NUM_W-1];
			hex_s2     <= hex_s1;
			dot_pos_s2 <= dot_s1;
		end
	end

endmodule

`default_nettype wire

// ===== design/ssd_pattern.sv =====
// ----------------------------------------------------------------------------
// ssd_pattern
// per-digit segment bytes: decimal digits from quotients, hex nibbles,
// font lookup, dot and minus sign
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_pattern #(
	parameter int NUM_DIGITS = 4
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          valid_s2,
	output logic                                               ready_s2,
	input  wire ssd_pkg::ld_ctl_t                              ctl_s2,
	input  wire logic [ssd_pkg::QUOT_N-1:0][ssd_pkg::NUM_W-1:0] quot_s2,
	input  wire logic                                          neg_s2,
	input  wire logic [ssd_pkg::HEX_W-1:0]                     hex_s2,
	input  wire logic [ssd_pkg::DOT_W-1:0]                     dot_pos_s2,
	input  wire logic [ssd_pkg::SEG_W-1:0]                     minus_pattern,
	input  wire logic [ssd_pkg::SEG_W-1:0]                     dot_mask,
	output logic                                               valid_s3,
	input  wire logic                                          down_ready,
	output ssd_pkg::ld_ctl_t                                   ctl_s3,
	output logic [NUM_DIGITS-1:0][ssd_pkg::SEG_W-1:0]          pat_s3
);

	localparam int NIB_N = ssd_pkg::HEX_W / ssd_pkg::NIB_W;

	logic [NUM_DIGITS-1:0][ssd_pkg::SEG_W-1:0] pat_d;

	assign ready_s2 = !valid_s3 || down_ready;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
		logic [ssd_pkg::NIB_W-1:0] dec_dig;
		logic [ssd_pkg::NIB_W-1:0] hex_nib;
		logic                      dot_on;

		// digit = q_i - 10 * q_(i+1)
		if (i < ssd_pkg::QUOT_N - 1) begin : g_mid
			logic [ssd_pkg::NUM_W-1:0] ten_q;
			assign ten_q   = {quot_s2[i+1][ssd_pkg::NUM_W-4:0], 3'b000}
			               + {quot_s2[i+1][ssd_pkg::NUM_W-2:0], 1'b0};
			assign dec_dig = ssd_pkg::NIB_W'(quot_s2[i] - ten_q);
		end else if (i == ssd_pkg::QUOT_N - 1) begin : g_top
			assign dec_dig = ssd_pkg::NIB_W'(quot_s2[i]);
		end else begin : g_zero
			assign dec_dig = '0;
		end

		if (i < NIB_N) begin : g_nib
			assign hex_nib = hex_s2[i*ssd_pkg::NIB_W +: ssd_pkg::NIB_W];
		end else begin : g_nonib
			assign hex_nib = '0;
		end

		assign dot_on = ({1'b0, dot_pos_s2} == (ssd_pkg::DOT_W + 1)'(i + 1));

		always_comb begin
			if (ctl_s2.is_dec && neg_s2 && (i == NUM_DIGITS - 1)) begin
				pat_d[i] = minus_pattern;
			end else if (ctl_s2.is_dec) begin
				pat_d[i] = ssd_pkg::seg_font(dec_dig) | (dot_on ? dot_mask : '0);
			end else begin
				pat_d[i] = ssd_pkg::seg_font(hex_nib) | (dot_on ? dot_mask : '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			ctl_s3 <= ctl_s2;
			pat_s3 <= pat_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/ssd_scan.sv =====
// ----------------------------------------------------------------------------
// ssd_scan
// scan state (digit slot, dwell counter, frames left, bank) and the result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_scan #(
	parameter int NUM_DIGITS = 4
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        valid_s3,
	output logic                                             ready_s3,
	input  wire ssd_pkg::ld_ctl_t                            ctl_s3,
	input  wire logic [NUM_DIGITS-1:0][ssd_pkg::SEG_W-1:0]   pat_s3,
	input  wire logic [ssd_pkg::DWELL_W-1:0]                 dwell_ticks,
	input  wire logic [ssd_pkg::DWELL_W-1:0]                 yellow_dwell_ticks,
	output logic                                             out_valid_q,
	input  wire logic                                        out_ready,
	output logic [ssd_pkg::SEG_W-1:0]                        seg_q,
	output logic [ssd_pkg::EN_W-1:0]                         en_q,
	output logic                                             busy_q,
	output logic                                             rej_q
);

	localparam int SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int IDX_W  = 5;

	logic                                        running_q, running_n;
	logic                                        yellow_q, yellow_n;
	logic                                        bank_q, bank_n;
	logic [NUM_DIGITS-1:0][ssd_pkg::SEG_W-1:0]   pat_q, pat_n;
	logic [SLOT_W-1:0]                           slot_q, slot_n;
	logic [ssd_pkg::DWELL_W-1:0]                 cnt_q, cnt_n;
	logic [ssd_pkg::FRAMES_W-1:0]                frames_q, frames_n;

	logic                                        adv;
	logic [ssd_pkg::DWELL_W-1:0]                 dwell_eff;
	logic [ssd_pkg::DWELL_W:0]                   cnt_inc;
	logic [IDX_W-1:0]                            en_idx;
	logic [ssd_pkg::SEG_W-1:0]                   seg_d;
	logic [ssd_pkg::EN_W-1:0]                    en_d;
	logic                                        rej_d;

	assign ready_s3 = !out_valid_q || out_ready;
	assign adv      = valid_s3 && ready_s3;

	always_comb begin
		dwell_eff = yellow_q ? yellow_dwell_ticks : dwell_ticks;
		if (dwell_eff == '0) begin
			dwell_eff = ssd_pkg::DWELL_W'(1);
		end
		cnt_inc = {1'b0, cnt_q} + (ssd_pkg::DWELL_W + 1)'(1);
		en_idx  = IDX_W'(slot_q) + (bank_q ? IDX_W'(NUM_DIGITS) : '0);
	end

	always_comb begin
		running_n = running_q;
		yellow_n  = yellow_q;
		bank_n    = bank_q;
		pat_n     = pat_q;
		slot_n    = slot_q;
		cnt_n     = cnt_q;
		frames_n  = frames_q;
		seg_d     = '0;
		en_d      = '0;
		rej_d     = 1'b0;

		if (ctl_s3.is_load) begin
			slot_n = '0;
			cnt_n  = '0;
			if (ctl_s3.rejected) begin
				running_n = 1'b0;
				frames_n  = '0;
				rej_d     = 1'b1;
			end else begin
				pat_n     = pat_s3;
				yellow_n  = ctl_s3.yellow;
				bank_n    = ctl_s3.bank;
				frames_n  = ctl_s3.frames_run;
				running_n = (ctl_s3.frames_run != '0);
			end
		end else if (!running_q) begin
			running_n = 1'b0;
			frames_n  = '0;
			slot_n    = '0;
			cnt_n     = '0;
		end else begin
			seg_d = pat_q[slot_q];
			for (int b = 0; b < ssd_pkg::EN_W; b++) begin
				en_d[b] = (en_idx == IDX_W'(b));
			end
			if (cnt_inc >= {1'b0, dwell_eff}) begin
				cnt_n = '0;
				if (slot_q == SLOT_W'(NUM_DIGITS - 1)) begin
					slot_n   = '0;
					frames_n = frames_q - ssd_pkg::FRAMES_W'(1);
					if (yellow_q) begin
						bank_n = !bank_q;
					end
					if (frames_n == '0) begin
						running_n = 1'b0;
					end
				end else begin
					slot_n = slot_q + SLOT_W'(1);
				end
			end else begin
				cnt_n = cnt_inc[ssd_pkg::DWELL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			yellow_q    <= 1'b0;
			bank_q      <= 1'b0;
			pat_q       <= '0;
			slot_q      <= '0;
			cnt_q       <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				running_q   <= running_n;
				yellow_q    <= yellow_n;
				bank_q      <= bank_n;
				pat_q       <= pat_n;
				slot_q      <= slot_n;
				cnt_q       <= cnt_n;
				frames_q    <= frames_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_q  <= seg_d;
			en_q   <= en_d;
			busy_q <= running_n;
			rej_q  <= rej_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/seven_segment_scan_driver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// multiplexed seven-segment driver with red and green digit banks
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. A load beat (tuser = 1)
// latches the segment bytes for all digits (hex, signed decimal or yellow hex)
// and starts a run of frames, unless it is an out-of-range decimal load,
// which is rejected and stops the scan; while a run is active, a tick beat
// (tuser = 0) drives one digit's segment byte and a one-hot enable on the
// active bank, advancing the scan after each dwell. The block takes one beat
// per clock when the output side is not stalled and holds up to four beats
// in flight: input register, quotient stage, pattern stage and the result
// register. Decimal quotients come from reciprocal multiplies in the quotient
// stage; all scan state lives in the last stage, so the sequence of beats is
// handled strictly in order. Configuration writes are taken at any time but
// must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver #(
	parameter int NUM_DIGITS = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input beats
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// mode[1:0], hex_value[17:2], signed_number[33:18], dot_pos[36:34],
	// color[37], frames[53:38], zero pad[55:54]
	input  wire logic [55:0]                         s_tdata,
	// op[0]: 0 tick, 1 load
	input  wire logic [0:0]                          s_tuser,
	// result beats
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// segments[7:0], digit_enables[15:8], busy_res[16], rejected[17],
	// zero pad[23:18]
	output logic [23:0]                              m_tdata,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ssd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ssd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration
	logic [ssd_pkg::DWELL_W-1:0] dwell_q;
	logic [ssd_pkg::DWELL_W-1:0] ydwell_q;
	logic [ssd_pkg::SEG_W-1:0]   minus_q;
	logic [ssd_pkg::SEG_W-1:0]   dotmask_q;

	// front end to pattern stage
	logic                                             valid_s2;
	logic                                             ready_s2;
	ssd_pkg::ld_ctl_t                                 ctl_s2;
	logic [ssd_pkg::QUOT_N-1:0][ssd_pkg::NUM_W-1:0]   quot_s2;
	logic                                             neg_s2;
	logic [ssd_pkg::HEX_W-1:0]                        hex_s2;
	logic [ssd_pkg::DOT_W-1:0]                        dot_pos_s2;

	// pattern stage to scan stage
	logic                                             valid_s3;
	logic                                             ready_s3;
	ssd_pkg::ld_ctl_t                                 ctl_s3;
	logic [NUM_DIGITS-1:0][ssd_pkg::SEG_W-1:0]        pat_s3;

	// result register
	logic [ssd_pkg::SEG_W-1:0]                        seg_q;
	logic [ssd_pkg::EN_W-1:0]                         en_q;
	logic                                             busy_q;
	logic                                             rej_q;

	ssd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dwell_q   (dwell_q),
		.ydwell_q  (ydwell_q),
		.minus_q   (minus_q),
		.dotmask_q (dotmask_q)
	);

	// input register, decode, range check, decimal quotients
	ssd_front #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.op            (s_tuser[0]),
		.mode          (s_tdata[1:0]),
		.hex_value     (s_tdata[17:2]),
		.signed_number (s_tdata[33:18]),
		.dot_pos       (s_tdata[36:34]),
		.color         (s_tdata[37]),
		.frames        (s_tdata[53:38]),
		.valid_s2      (valid_s2),
		.down_ready    (ready_s2),
		.ctl_s2        (ctl_s2),
		.quot_s2       (quot_s2),
		.neg_s2        (neg_s2),
		.hex_s2        (hex_s2),
		.dot_pos_s2    (dot_pos_s2)
	);

	// segment bytes for every digit
	ssd_pattern #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_pattern (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.ready_s2      (ready_s2),
		.ctl_s2        (ctl_s2),
		.quot_s2       (quot_s2),
		.neg_s2        (neg_s2),
		.hex_s2        (hex_s2),
		.dot_pos_s2    (dot_pos_s2),
		.minus_pattern (minus_q),
		.dot_mask      (dotmask_q),
		.valid_s3      (valid_s3),
		.down_ready    (ready_s3),
		.ctl_s3        (ctl_s3),
		.pat_s3        (pat_s3)
	);

	// scan state and result register
	ssd_scan #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_scan (
		.clk                (clk),
		.arst_n             (arst_n),
		.valid_s3           (valid_s3),
		.ready_s3           (ready_s3),
		.ctl_s3             (ctl_s3),
		.pat_s3             (pat_s3),
		.dwell_ticks        (dwell_q),
		.yellow_dwell_ticks (ydwell_q),
		.out_valid_q        (m_tvalid),
		.out_ready          (m_tready),
		.seg_q              (seg_q),
		.en_q               (en_q),
		.busy_q             (busy_q),
		.rej_q              (rej_q)
	);

	assign m_tdata = {6'b000000, rej_q, busy_q, en_q, seg_q};

endmodule

`default_nettype wire
